[rtl/elcd_pkg.sv]
// Shared types, status codes and name tables for the escaped literal character decoder.
`default_nettype none

package elcd_pkg;

    localparam int CODE_WIDTH_DEF = 32;
    localparam int CP_W           = 32;
    localparam int ST_W           = 3;
    localparam int NAME_COUNT     = 7;
    localparam int NAME_IDX_W     = 3;
    localparam int NAME_POS_W     = 4;
    localparam int RADIX_W        = 6;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_UNKNOWN  = 3'd1;
    localparam logic [ST_W-1:0] ST_BADFORM  = 3'd2;
    localparam logic [ST_W-1:0] ST_UTF8     = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

    localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [ST_W-1:0] status;
    } t_result;

    function automatic logic [NAME_POS_W-1:0] name_len(input logic [NAME_IDX_W-1:0] idx);
        logic [NAME_POS_W-1:0] len;
        case (idx)
            3'd0:    len = 4'd5;
            3'd1:    len = 4'd3;
            3'd2:    len = 4'd8;
            3'd3:    len = 4'd6;
            3'd4:    len = 4'd9;
            3'd5:    len = 4'd6;
            3'd6:    len = 4'd6;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] name_code(input logic [NAME_IDX_W-1:0] idx);
        logic [7:0] code;
        case (idx)
            3'd0:    code = 8'h20;
            3'd1:    code = 8'h09;
            3'd2:    code = 8'h0A;
            3'd3:    code = 8'h0D;
            3'd4:    code = 8'h08;
            3'd5:    code = 8'h7B;
            3'd6:    code = 8'h7D;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Character at a position of a name; text is right-aligned, first char highest.
    function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] idx,
                                             input logic [NAME_POS_W-1:0] pos);
        logic [71:0]           txt;
        logic [NAME_POS_W-1:0] len;
        logic [NAME_POS_W-1:0] off;
        logic [71:0]           sh;
        case (idx)
            3'd0:    txt = 72'("space");
            3'd1:    txt = 72'("tab");
            3'd2:    txt = 72'("linefeed");
            3'd3:    txt = 72'("return");
            3'd4:    txt = 72'("backspace");
            3'd5:    txt = 72'("lbrace");
            3'd6:    txt = 72'("rbrace");
            default: txt = '0;
        endcase
        len = name_len(idx);
        off = len - pos - 4'd1;
        sh  = txt >> {off, 3'b000};
        return (pos < len) ? sh[7:0] : 8'h00;
    endfunction

    function automatic logic [RADIX_W-1:0] digit_of(input logic [7:0] b);
        logic [RADIX_W-1:0] d;
        if (b >= "0" && b <= "9") begin
            d = RADIX_W'(b - "0");
        end else if (b >= "a" && b <= "z") begin
            d = RADIX_W'(b - "a" + 8'd10);
        end else if (b >= "A" && b <= "Z") begin
            d = RADIX_W'(b - "A" + 8'd10);
        end else begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/escaped_literal_char_decoder_top.sv]
// Top level of the escaped literal character decoder: input register, decode core, result register.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------
//  in      | i_valid | o_stall | i_char_byte
//  out     | o_valid | i_stall | o_code_point, o_status
//
// One byte per cycle while o_stall is low; each result is held in the result register.
// The byte register feeds the core, whose state settles in the same cycle.
// Reset (synchronous) returns the parser to idle and empties both registers.
// A stalled result holds; one more byte is taken into the input register meanwhile,
// and bytes that finish no character keep flowing behind a stalled result.
`default_nettype none

module escaped_literal_char_decoder_top
    import elcd_pkg::*;
#(
    parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [7:0]      i_char_byte,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [CP_W-1:0]      o_code_point,
    output logic [ST_W-1:0]      o_status
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       fire;
    logic       has_result;
    t_result    result;

    elcd_core #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (r_in_byte),
        .o_has_result (has_result),
        .o_result     (result)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && (!has_result || out_free);
    assign o_stall  = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_char_byte;
        end
        if (fire && has_result) begin
            r_out <= result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_out.code_point;
    assign o_status     = r_out.status;

endmodule

`default_nettype wire

[rtl/elcd_core.sv]
// Parse state and per-byte decode logic for the escaped literal character decoder.
`default_nettype none

module elcd_core
    import elcd_pkg::*;
#(
    parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire logic [7:0] i_byte,
    output logic         o_has_result,
    output t_result      o_result
);

    localparam int ACC_W  = (CODE_WIDTH >= 32) ? 32 : CODE_WIDTH;
    localparam int WIDE_W = ACC_W + RADIX_W + 1;

    typedef enum logic [2:0] {
        M_IDLE, M_UTF8, M_ESC, M_BRACE, M_DEC, M_DIGITS, M_UPLUS, M_NAME
    } t_mode;

    t_mode                  r_mode,   n_mode;
    logic [ACC_W-1:0]       r_acc,    n_acc;
    logic [RADIX_W-1:0]     r_radix,  n_radix;
    logic [NAME_COUNT-1:0]  r_cand,   n_cand;
    logic [NAME_POS_W-1:0]  r_pos,    n_pos;
    logic [1:0]             r_left,   n_left;

    logic [RADIX_W-1:0]     dig;
    logic [WIDE_W-1:0]      acc_wide;
    logic                   acc_ovf;
    logic [NAME_COUNT-1:0]  name_match;
    logic                   name_done;
    logic [7:0]             done_code;

    logic                   res_valid;
    logic [CP_W-1:0]        res_cp;
    logic [ST_W-1:0]        res_st;

    assign dig      = digit_of(i_byte);
    assign acc_wide = WIDE_W'(r_acc) * WIDE_W'(r_radix) + WIDE_W'(dig);
    assign acc_ovf  = |acc_wide[WIDE_W-1:ACC_W];

    always_comb begin
        name_done = 1'b0;
        done_code = 8'h00;
        for (int i = 0; i < NAME_COUNT; i++) begin
            name_match[i] = r_cand[i] && (r_pos < name_len(NAME_IDX_W'(i)))
                            && (name_char(NAME_IDX_W'(i), r_pos) == i_byte);
            if (!name_done && r_cand[i] && (name_len(NAME_IDX_W'(i)) == r_pos)) begin
                name_done = 1'b1;
                done_code = name_code(NAME_IDX_W'(i));
            end
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_radix   = r_radix;
        n_cand    = r_cand;
        n_pos     = r_pos;
        n_left    = r_left;
        res_valid = 1'b0;
        res_cp    = '0;
        res_st    = ST_OK;

        case (r_mode)
            M_IDLE: begin
                if (i_byte == "\\") begin
                    n_mode = M_ESC;
                end else if (!i_byte[7]) begin
                    res_valid = 1'b1;
                    res_cp    = CP_W'(i_byte);
                end else if (i_byte inside {[8'hC0:8'hDF]}) begin
                    n_acc  = ACC_W'(i_byte[4:0]);
                    n_left = 2'd1;
                    n_mode = M_UTF8;
                end else if (i_byte inside {[8'hE0:8'hEF]}) begin
                    n_acc  = ACC_W'(i_byte[3:0]);
                    n_left = 2'd2;
                    n_mode = M_UTF8;
                end else if (i_byte inside {[8'hF0:8'hF7]}) begin
                    n_acc  = ACC_W'(i_byte[2:0]);
                    n_left = 2'd3;
                    n_mode = M_UTF8;
                end else begin
                    res_valid = 1'b1;
                    res_st    = ST_UTF8;
                end
            end
            M_UTF8: begin
                if (i_byte[7:6] != 2'b10) begin
                    res_valid = 1'b1;
                    res_st    = ST_UTF8;
                end else begin
                    n_acc  = {r_acc[ACC_W-7:0], i_byte[5:0]};
                    n_left = r_left - 2'd1;
                    if (r_left == 2'd1) begin
                        res_valid = 1'b1;
                        res_cp    = CP_W'(n_acc);
                    end
                end
            end
            M_ESC: begin
                res_valid = 1'b1;
                case (i_byte)
                    "n":     res_cp = CP_W'(8'h0A);
                    "r":     res_cp = CP_W'(8'h0D);
                    "t":     res_cp = CP_W'(8'h09);
                    "b":     res_cp = CP_W'(8'h08);
                    "s":     res_cp = CP_W'(8'h20);
                    "f":     res_cp = CP_W'(8'h0C);
                    "\"":    res_cp = CP_W'(8'h22);
                    "\\":    res_cp = CP_W'(8'h5C);
                    "{": begin
                        res_valid = 1'b0;
                        n_mode    = M_BRACE;
                    end
                    default: res_st = ST_UNKNOWN;
                endcase
            end
            M_BRACE, M_NAME: begin
                if (r_mode == M_BRACE && i_byte >= "0" && i_byte <= "9") begin
                    n_acc   = ACC_W'(i_byte[3:0]);
                    n_radix = RADIX_W'(10);
                    n_mode  = M_DEC;
                end else if (r_mode == M_BRACE && i_byte == "U") begin
                    n_mode = M_UPLUS;
                end else if (i_byte == "}") begin
                    res_valid = 1'b1;
                    if (name_done) begin
                        res_cp = CP_W'(done_code);
                    end else begin
                        res_st = ST_BADFORM;
                    end
                end else if (name_match == '0) begin
                    res_valid = 1'b1;
                    res_st    = ST_BADFORM;
                end else begin
                    n_mode = M_NAME;
                    n_cand = name_match;
                    n_pos  = r_pos + 4'd1;
                end
            end
            M_DEC: begin
                if (i_byte >= "0" && i_byte <= "9") begin
                    if (acc_ovf) begin
                        res_valid = 1'b1;
                        res_st    = ST_OVERFLOW;
                    end else begin
                        n_acc = acc_wide[ACC_W-1:0];
                    end
                end else if (i_byte == "}") begin
                    res_valid = 1'b1;
                    res_cp    = CP_W'(r_acc);
                end else if (i_byte == "r") begin
                    if (r_acc < ACC_W'(2) || r_acc > ACC_W'(36)) begin
                        res_valid = 1'b1;
                        res_st    = ST_BADFORM;
                    end else begin
                        n_radix = r_acc[RADIX_W-1:0];
                        n_acc   = '0;
                        n_mode  = M_DIGITS;
                    end
                end else begin
                    res_valid = 1'b1;
                    res_st    = ST_BADFORM;
                end
            end
            M_UPLUS: begin
                if (i_byte != "+") begin
                    res_valid = 1'b1;
                    res_st    = ST_BADFORM;
                end else begin
                    n_radix = RADIX_W'(16);
                    n_acc   = '0;
                    n_mode  = M_DIGITS;
                end
            end
            M_DIGITS: begin
                if (i_byte == "}") begin
                    res_valid = 1'b1;
                    res_cp    = CP_W'(r_acc);
                end else if (dig >= r_radix) begin
                    res_valid = 1'b1;
                    res_st    = ST_BADFORM;
                end else if (acc_ovf) begin
                    res_valid = 1'b1;
                    res_st    = ST_OVERFLOW;
                end else begin
                    n_acc = acc_wide[ACC_W-1:0];
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        // every result, and any stray mode, returns the parser to idle
        if (res_valid || r_mode == M_IDLE && n_mode == M_IDLE) begin
            n_mode  = M_IDLE;
            n_acc   = '0;
            n_radix = RADIX_W'(10);
            n_cand  = '1;
            n_pos   = '0;
            n_left  = '0;
        end
    end

    assign o_has_result        = res_valid;
    assign o_result.code_point = (res_st == ST_OK) ? res_cp : '0;
    assign o_result.status     = res_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= '0;
            r_radix <= RADIX_W'(10);
            r_cand  <= '1;
            r_pos   <= '0;
            r_left  <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_radix <= n_radix;
            r_cand  <= n_cand;
            r_pos   <= n_pos;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

[rtl/elcd_checker.sv]
// Port-level assertions for the escaped literal character decoder, bound to the top level.
`default_nettype none

module elcd_checker
    import elcd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            o_stall,
    input  wire logic            o_valid,
    input  wire logic            i_stall,
    input  wire logic [CP_W-1:0] o_code_point,
    input  wire logic [ST_W-1:0] o_status
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("transaction pending after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_UNKNOWN || o_status == ST_BADFORM
                    || o_status == ST_UTF8 || o_status == ST_OVERFLOW)
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_code_point == '0)
        else $error("error transaction carries a code point");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_point) && $stable(o_status))
        else $error("stalled output transaction changed");

endmodule

bind escaped_literal_char_decoder_top elcd_checker u_elcd_checker (.*);

`default_nettype wire
